### design/rlcm_pkg.sv
// Package for the running LCM block: widths, shared types and the sequencer states.
// No dependencies; every design file imports it.
package rlcm_pkg;

  // Bits of the period that take part; the rest of the item is ignored.
  localparam int PERIOD_WIDTH = 32;
  // Width of the accumulator and of the saturation limit.
  localparam int RESULT_WIDTH = 64;
  // Port widths, fixed by the item format.
  localparam int S_DATA_W     = 32;
  localparam int M_DATA_W     = 64;
  // The multiplier works on halves of this size of the multiplicand.
  localparam int HALF_W       = 32;
  localparam int PROD_W       = 2 * HALF_W + PERIOD_WIDTH;
  localparam int PP_W         = HALF_W + PERIOD_WIDTH;
  // Divider bit counter must hold RESULT_WIDTH itself.
  localparam int DIV_CNT_W    = $clog2(RESULT_WIDTH + 1);

  typedef logic [RESULT_WIDTH-1:0] res_t;
  typedef logic [PERIOD_WIDTH-1:0] per_t;

  localparam res_t RES_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_QUO,
    ST_MUL,
    ST_DONE
  } state_t;

endpackage

### design/rlcm_div.sv
// Restoring divider, one quotient bit a cycle, shared for Euclid remainders and the quotient.
// Depends on rlcm_pkg.
module rlcm_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rlcm_pkg::res_t      dividend,
  input  rlcm_pkg::res_t      divisor,
  output logic                done,
  output rlcm_pkg::res_t      quotient,
  output rlcm_pkg::res_t      remainder
);
  import rlcm_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  res_t                 quo;
  res_t                 rem;
  res_t                 dvs;

  logic [RESULT_WIDTH:0]   trial;
  logic [RESULT_WIDTH+1:0] diff;
  logic                    fits;
  res_t                    rem_next;

  // One trial subtraction of the shifted partial remainder.
  always_comb begin
    trial    = {rem, quo[RESULT_WIDTH-1]};
    diff     = {1'b0, trial} - {2'b00, dvs};
    fits     = !diff[RESULT_WIDTH+1];
    rem_next = fits ? diff[RESULT_WIDTH-1:0] : trial[RESULT_WIDTH-1:0];
  end

  // Control: bit counter, busy and the completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(RESULT_WIDTH);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out at the top as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[RESULT_WIDTH-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  // A division is never started on a zero divisor or over a running one.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    start |-> divisor != '0) else $error("division started with a zero divisor");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("division started while busy");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("done without a running division");

endmodule

### design/rlcm_mul.sv
// Two-step multiplier: one PERIOD_WIDTH x HALF_W multiplier used for each half of the quotient.
// Depends on rlcm_pkg.
module rlcm_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  rlcm_pkg::res_t              mcand,
  input  rlcm_pkg::per_t              mplier,
  output logic                        done,
  output logic [rlcm_pkg::PROD_W-1:0] product
);
  import rlcm_pkg::*;

  logic [1:0]          step;
  logic [2*HALF_W-1:0] q_ext;
  per_t                p_r;
  logic [PP_W-1:0]     lo_pp;
  logic [PP_W-1:0]     hi_pp;
  logic [HALF_W-1:0]   m_a;
  logic [PP_W-1:0]     m_out;

  // The shared multiplier takes the low half first, then the high half.
  always_comb begin
    m_a   = step[1] ? q_ext[2*HALF_W-1:HALF_W] : q_ext[HALF_W-1:0];
    m_out = PP_W'(m_a) * PP_W'(p_r);
  end

  // Step sequencing: step[0] is the low half, step[1] the high half.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= 2'b01;
      end else if (step[0]) begin
        step <= 2'b10;
      end else if (step[1]) begin
        step <= 2'b00;
        done <= 1'b1;
      end
    end
  end

  // Operand capture and partial product registers.
  always_ff @(posedge clk) begin
    if (start) begin
      q_ext <= (2*HALF_W)'(mcand);
      p_r   <= mplier;
    end
    if (step[0]) begin
      lo_pp <= m_out;
    end
    if (step[1]) begin
      hi_pp <= m_out;
    end
  end

  // Partial products combined once both are held.
  assign product = PROD_W'({hi_pp, {HALF_W{1'b0}}}) + PROD_W'(lo_pp);

  a_mul_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0(step)) else $error("multiplier in two steps at once");
  a_mul_start: assert property (@(posedge clk) disable iff (rst)
    start |-> step == 2'b00) else $error("multiply started while busy");
  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(step[1])) else $error("multiply done out of sequence");

endmodule

### design/running_lcm_of_periods.sv
// Top level of the running LCM (hyperperiod) block: sequencer, accumulator and output register.
// Depends on rlcm_pkg, rlcm_div and rlcm_mul.
//
// Each item carries a task period and a start flag and returns one item with the running least
// common multiple and a sticky overflow flag. A start item loads its period and clears the flag.
// Start items, zero periods, items while the flag is set and the first period into an empty
// accumulator skip the calculation and go straight to the output state. Any other item runs
// Euclid's algorithm on the single shared divider, up to about 47 divisions for 32-bit periods,
// then divides the accumulator by the gcd, multiplies that quotient by the period in the
// two-step multiplier and loads the output register.
// The input is not ready while an item is being worked on; a finished result waits in the output
// register, so the next item can be taken before it is collected.
module running_lcm_of_periods (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] period
  input  logic [0:0]  s_tuser,   // [0] start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] lcm_value
  output logic [0:0]  m_tuser    // [0] overflow
);
  import rlcm_pkg::*;

  state_t state;
  state_t state_next;

  res_t   acc;
  logic   ovf;
  res_t   gy;
  per_t   p_r;

  logic   s_acc;
  per_t   p_in;
  logic   need_calc;
  logic   out_free;

  logic   div_start;
  res_t   div_a;
  res_t   div_b;
  logic   div_done;
  res_t   div_quo;
  res_t   div_rem;

  logic              mul_start;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;
  logic              prod_ovf;

  // Input decode.
  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign p_in      = s_tdata[PERIOD_WIDTH-1:0];
  assign need_calc = !s_tuser[0] && (p_in != '0) && (acc != '0) && !ovf;
  assign out_free  = !m_tvalid || m_tready;
  assign prod_ovf  = |mul_prod[PROD_W-1:RESULT_WIDTH];

  // Shared units.
  rlcm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  rlcm_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (div_quo),
    .mplier  (p_r),
    .done    (mul_done),
    .product (mul_prod)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_acc) begin
          state_next = need_calc ? ST_GCD : ST_DONE;
        end
      end
      ST_GCD: begin
        if (div_done && (div_rem == '0)) begin
          state_next = ST_QUO;
        end
      end
      ST_QUO: begin
        if (div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Unit commands and operand selection.
  always_comb begin
    div_start = 1'b0;
    div_a     = acc;
    div_b     = gy;
    mul_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // First Euclid step: period mod accumulator.
        div_start = s_acc && need_calc;
        div_a     = RESULT_WIDTH'(p_in);
        div_b     = acc;
      end
      ST_GCD: begin
        if (div_done) begin
          div_start = 1'b1;
          if (div_rem != '0) begin
            div_a = gy;
            div_b = div_rem;
          end else begin
            // gcd found in gy: divide the accumulator by it.
            div_a = acc;
            div_b = gy;
          end
        end
      end
      ST_QUO: begin
        mul_start = div_done;
      end
      ST_MUL, ST_DONE: begin
        div_start = 1'b0;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Accumulator and overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      ovf <= 1'b0;
    end else if (s_acc) begin
      if (s_tuser[0]) begin
        acc <= RESULT_WIDTH'(p_in);
        ovf <= 1'b0;
      end else if ((p_in != '0) && (acc == '0)) begin
        acc <= RESULT_WIDTH'(p_in);
      end
    end else if ((state == ST_MUL) && mul_done) begin
      if (prod_ovf) begin
        acc <= RES_MAX;
        ovf <= 1'b1;
      end else begin
        acc <= mul_prod[RESULT_WIDTH-1:0];
      end
    end
  end

  // Euclid working value and the held period.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      p_r <= p_in;
      gy  <= acc;
    end else if ((state == ST_GCD) && div_done && (div_rem != '0)) begin
      gy <= div_rem;
    end
  end

  // Output register: loaded when the result is ready and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      m_tdata    <= M_DATA_W'(acc);
      m_tuser[0] <= ovf;
    end
  end

  // Overflow always comes with a saturated accumulator, and Euclid never divides by zero.
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    ovf |-> acc == RES_MAX) else $error("overflow flag without saturated accumulator");
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GCD) |-> gy != '0) else $error("Euclid working value is zero");
  a_out_sat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tdata == M_DATA_W'(RES_MAX))
    else $error("overflow item without saturated value");

endmodule
